/* hdl/trrc_pkg.sv */
// trrc_pkg: shared types, wiring tables and lookup functions of the rotor cipher
// used by trrc_cell and three_rotor_reflecting_cipher_unit, no dependencies
`default_nettype none

package trrc_pkg;

  localparam int unsigned ALPHABET_SIZE = 26;
  localparam int unsigned WIRE_W        = 8 * ALPHABET_SIZE;
  localparam int unsigned NUM_CELLS     = 7;

  // configuration register indexes
  localparam logic [2:0] CFG_RIGHT_TYPE  = 3'd0;
  localparam logic [2:0] CFG_MIDDLE_TYPE = 3'd1;
  localparam logic [2:0] CFG_LEFT_TYPE   = 3'd2;
  localparam logic [2:0] CFG_REFLECTOR   = 3'd3;
  localparam logic [2:0] CFG_RIGHT_START = 3'd4;
  localparam logic [2:0] CFG_MID_START   = 3'd5;
  localparam logic [2:0] CFG_LEFT_START  = 3'd6;

  // rotor slots in the position vector
  localparam logic [1:0] ROTOR_RIGHT  = 2'd0;
  localparam logic [1:0] ROTOR_MIDDLE = 2'd1;
  localparam logic [1:0] ROTOR_LEFT   = 2'd2;

  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  localparam logic [WIRE_W-1:0] ROTOR_WIRING [8] = '{
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
    "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO",
    "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK",
    "JPGVOUMFYQBENHZRDKASXLICTW",
    "NZJHGRCXMYSWBOUFAIVLPEKQDT",
    "FKQHTLXOCBJSPDZRAMEWNIUYGV"
  };

  // reflector select three behaves as B
  localparam logic [WIRE_W-1:0] REFL_WIRING [4] = '{
    "EJMZALYXVBWFCRQUONTSPIKHGD",
    "YRUHQSLDPXNGOKMIEBFZCWVJAT",
    "FVPJIAOYEDRZXWGCTKUQSBNMHL",
    "YRUHQSLDPXNGOKMIEBFZCWVJAT"
  };

  localparam logic [4:0] NOTCH_Q = 5'd16;
  localparam logic [4:0] NOTCH_E = 5'd4;
  localparam logic [4:0] NOTCH_V = 5'd21;
  localparam logic [4:0] NOTCH_J = 5'd9;
  localparam logic [4:0] NOTCH_Z = 5'd25;
  localparam logic [4:0] NOTCH_M = 5'd12;

  typedef enum logic [1:0] {
    PASS_FWD,
    PASS_REFL,
    PASS_REV
  } pass_e;

  typedef struct packed {
    pass_e      op;
    logic [2:0] slot;
    logic [1:0] rotor;
    logic [1:0] refl;
  } cell_ctrl_t;

  typedef struct packed {
    logic            letter;
    logic [7:0]      raw;
    logic [4:0]      x;
    logic [2:0][4:0] pos;
  } trrc_item_t;

  // letter index of one character of a 26-letter wiring string
  function automatic logic [4:0] char_at(logic [WIRE_W-1:0] w, logic [4:0] idx);
    logic [7:0]  ch;
    int unsigned sh;
    sh = 0;
    if (idx < 5'(ALPHABET_SIZE)) begin
      sh = 8 * (ALPHABET_SIZE - 1 - int'(idx));
    end
    ch = w[sh +: 8];
    return 5'(ch - CHAR_UP_A);
  endfunction

  function automatic logic [4:0] rotor_wire(logic [2:0] slot, logic [4:0] idx);
    return char_at(ROTOR_WIRING[slot], idx);
  endfunction

  // inverse wiring: contact whose forward image is c
  function automatic logic [4:0] rotor_inv(logic [2:0] slot, logic [4:0] c);
    logic [4:0] found;
    found = '0;
    for (int j = 0; j < ALPHABET_SIZE; j++) begin
      if (rotor_wire(slot, 5'(j)) == c) begin
        found = 5'(j);
      end
    end
    return found;
  endfunction

  function automatic logic [4:0] refl_wire(logic [1:0] sel, logic [4:0] idx);
    return char_at(REFL_WIRING[sel], idx);
  endfunction

  function automatic logic [4:0] add_mod(logic [4:0] a, logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'(ALPHABET_SIZE)) begin
      s = s - 6'(ALPHABET_SIZE);
    end
    return s[4:0];
  endfunction

  function automatic logic [4:0] sub_mod(logic [4:0] a, logic [4:0] b);
    logic [5:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + 6'(ALPHABET_SIZE) - {1'b0, b};
    end
    return s[4:0];
  endfunction

  function automatic logic [4:0] inc_mod(logic [4:0] a);
    return add_mod(a, 5'd1);
  endfunction

  function automatic logic at_notch(logic [2:0] slot, logic [4:0] pos);
    logic hit;
    case (slot)
      3'd0:    hit = (pos == NOTCH_Q);
      3'd1:    hit = (pos == NOTCH_E);
      3'd2:    hit = (pos == NOTCH_V);
      3'd3:    hit = (pos == NOTCH_J);
      3'd4:    hit = (pos == NOTCH_Z);
      default: hit = (pos == NOTCH_Z) || (pos == NOTCH_M);
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

/* hdl/three_rotor_reflecting_cipher_unit.sv */
// three_rotor_reflecting_cipher_unit: top level of the three-rotor reflecting cipher
// holds configuration, rotor positions and stepping; the letter path is a chain
// of seven trrc_cell stages; depends on trrc_pkg and trrc_cell
//
// usage:
//  - input channel in_valid_i / in_stall_o / in_byte_i takes one byte per item
//  - output channel out_valid_o / out_stall_i / out_byte_o gives one byte per item
//  - lower-case letters are folded to upper case and enciphered; other bytes pass
//    through unchanged and leave the rotors where they are
//  - rotors step when a letter item is accepted and no configuration write is
//    taken; the stepped positions travel with the item through the cells:
//    right, middle, left, reflector, left, middle, right
//  - one register per cell: the item is registered in each of the seven cells in
//    turn before out_valid_o rises
//  - throughput is one item per cycle while out_stall_i is low; each cell holds one
//    item, so a stalled receiver fills the chain; input stalls once all 7 cells are full
//  - configuration port cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i is
//    always ready; write it only while no item is in flight
//  - reset selects rotors III, II, I (right to left), reflector B, positions zero
`default_nettype none

module three_rotor_reflecting_cipher_unit
  import trrc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input items
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  // result items
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  // configuration writes
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [4:0] cfg_data_i
);

  // configuration registers, rotor types as written
  logic [3:0]      right_type_q, mid_type_q, left_type_q;
  logic [1:0]      refl_q;
  logic [2:0][4:0] pos_q, pos_d;

  logic [2:0] slot_r, slot_m, slot_l;
  logic       cfg_we;
  logic [4:0] start_val;

  logic       in_accept;
  logic       is_letter;
  logic [7:0] upper;
  logic       mid_step, left_step;
  trrc_item_t entry_item;

  cell_ctrl_t ctrl  [NUM_CELLS];
  logic       valid [NUM_CELLS+1];
  logic       stall [NUM_CELLS+1];
  trrc_item_t item  [NUM_CELLS+1];

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // types 0 and 9..15 wrap onto rotors VIII and I..VII
  assign slot_r = right_type_q[2:0] - 3'd1;
  assign slot_m = mid_type_q[2:0] - 3'd1;
  assign slot_l = left_type_q[2:0] - 3'd1;

  // start values 26..31 wrap around
  assign start_val = (cfg_data_i >= 5'(ALPHABET_SIZE)) ?
                     (cfg_data_i - 5'(ALPHABET_SIZE)) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_type_q <= 4'd3;
      mid_type_q   <= 4'd2;
      left_type_q  <= 4'd1;
      refl_q       <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_RIGHT_TYPE:  right_type_q <= cfg_data_i[3:0];
        CFG_MIDDLE_TYPE: mid_type_q   <= cfg_data_i[3:0];
        CFG_LEFT_TYPE:   left_type_q  <= cfg_data_i[3:0];
        CFG_REFLECTOR:   refl_q       <= cfg_data_i[1:0];
        default:         ;
      endcase
    end
  end

  // letter detect and case folding
  always_comb begin
    upper = in_byte_i;
    if (in_byte_i inside {[CHAR_LOW_A:CHAR_LOW_Z]}) begin
      upper = in_byte_i - CASE_DELTA;
    end
    is_letter = upper inside {[CHAR_UP_A:CHAR_UP_Z]};
  end

  assign in_accept = in_valid_i && !in_stall_o;

  // stepping: middle double-steps on its own notch, carry from right notch
  assign left_step = at_notch(slot_m, pos_q[ROTOR_MIDDLE]);
  assign mid_step  = left_step || at_notch(slot_r, pos_q[ROTOR_RIGHT]);

  always_comb begin
    pos_d = pos_q;
    if (cfg_we) begin
      case (cfg_index_i)
        CFG_RIGHT_START: pos_d[ROTOR_RIGHT]  = start_val;
        CFG_MID_START:   pos_d[ROTOR_MIDDLE] = start_val;
        CFG_LEFT_START:  pos_d[ROTOR_LEFT]   = start_val;
        default:         ;
      endcase
    end else if (in_accept && is_letter) begin
      pos_d[ROTOR_RIGHT] = inc_mod(pos_q[ROTOR_RIGHT]);
      if (mid_step) begin
        pos_d[ROTOR_MIDDLE] = inc_mod(pos_q[ROTOR_MIDDLE]);
      end
      if (left_step) begin
        pos_d[ROTOR_LEFT] = inc_mod(pos_q[ROTOR_LEFT]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // item entering the chain carries the stepped positions
  always_comb begin
    entry_item.letter = is_letter;
    entry_item.raw    = in_byte_i;
    entry_item.x      = 5'(upper - CHAR_UP_A);
    entry_item.pos    = pos_d;
  end

  // cell roles along the chain
  always_comb begin
    ctrl[0] = '{op: PASS_FWD,  slot: slot_r, rotor: ROTOR_RIGHT,  refl: refl_q};
    ctrl[1] = '{op: PASS_FWD,  slot: slot_m, rotor: ROTOR_MIDDLE, refl: refl_q};
    ctrl[2] = '{op: PASS_FWD,  slot: slot_l, rotor: ROTOR_LEFT,   refl: refl_q};
    ctrl[3] = '{op: PASS_REFL, slot: slot_l, rotor: ROTOR_LEFT,   refl: refl_q};
    ctrl[4] = '{op: PASS_REV,  slot: slot_l, rotor: ROTOR_LEFT,   refl: refl_q};
    ctrl[5] = '{op: PASS_REV,  slot: slot_m, rotor: ROTOR_MIDDLE, refl: refl_q};
    ctrl[6] = '{op: PASS_REV,  slot: slot_r, rotor: ROTOR_RIGHT,  refl: refl_q};
  end

  assign valid[0]   = in_valid_i;
  assign item[0]    = entry_item;
  assign in_stall_o = stall[0];

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    trrc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[k]),
      .valid_i (valid[k]),
      .item_i  (item[k]),
      .stall_o (stall[k]),
      .valid_o (valid[k+1]),
      .item_o  (item[k+1]),
      .stall_i (stall[k+1])
    );
  end

  assign stall[NUM_CELLS] = out_stall_i;
  assign out_valid_o      = valid[NUM_CELLS];
  // letters leave as upper case, everything else as it came in
  assign out_byte_o = item[NUM_CELLS].letter ?
                      (CHAR_UP_A + {3'b000, item[NUM_CELLS].x}) : item[NUM_CELLS].raw;

  // a non-letter item leaves the rotors alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !is_letter && !cfg_we |=> $stable(pos_q))
    else $error("rotor moved on a non-letter item");

  // every letter steps the right rotor by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && is_letter && !cfg_we |=>
      pos_q[ROTOR_RIGHT] == inc_mod($past(pos_q[ROTOR_RIGHT])))
    else $error("right rotor did not step");

  // left rotor steps only together with the middle rotor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cfg_we) && !$stable(pos_q[ROTOR_LEFT]) |->
      !$stable(pos_q[ROTOR_MIDDLE]))
    else $error("left rotor stepped without the middle rotor");

  // positions stay inside the alphabet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q[ROTOR_RIGHT] < 5'(ALPHABET_SIZE) && pos_q[ROTOR_MIDDLE] < 5'(ALPHABET_SIZE)
      && pos_q[ROTOR_LEFT] < 5'(ALPHABET_SIZE))
    else $error("rotor position out of range");

endmodule

`default_nettype wire

/* hdl/trrc_cell.sv */
// trrc_cell: one pipeline cell, one rotor pass or the reflector per item
// depends on trrc_pkg
`default_nettype none

module trrc_cell
  import trrc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic       valid_i,
  input  wire trrc_item_t item_i,
  output logic            stall_o,
  output logic            valid_o,
  output trrc_item_t      item_o,
  input  wire logic       stall_i
);

  logic       valid_q;
  trrc_item_t item_q, item_d;
  logic       advance;
  logic [4:0] pos;
  logic [4:0] contact;

  assign advance = !valid_q || !stall_i;
  assign stall_o = !advance;
  assign pos     = item_i.pos[ctrl_i.rotor];
  assign contact = add_mod(item_i.x, pos);

  always_comb begin
    item_d = item_i;
    case (ctrl_i.op)
      PASS_FWD:  item_d.x = sub_mod(rotor_wire(ctrl_i.slot, contact), pos);
      PASS_REV:  item_d.x = sub_mod(rotor_inv(ctrl_i.slot, contact), pos);
      PASS_REFL: item_d.x = refl_wire(ctrl_i.refl, item_i.x);
      default:   item_d.x = item_i.x;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire
